// File: rtl/rae_pkg.sv
// shared types and constants for the ray / box entry-exit test
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rae_pkg;

   localparam int AXES      = 3;
   localparam int COORD_W   = 32;
   localparam int DIV_STEPS = 32;
   localparam int DIV_LAT   = DIV_STEPS + 2;
   localparam int LANE_LAT  = DIV_LAT + 2;
   localparam int MERGE_LAT = 3;
   localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;
   localparam int REQ_W     = 12 * COORD_W;
   localparam int RSP_W     = 64;

   localparam logic signed [31:0] TIME_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] TIME_MIN = 32'sh8000_0000;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic      miss;
      logic      outside;
      logic      v_zero;
      coord_type o;
      coord_type v;
      coord_type lo;
      coord_type hi;
   } lane_side_type;

   typedef struct packed {
      lane_side_type side;
      coord_type     near_t;
      coord_type     far_t;
   } lane_out_type;

   typedef struct packed {
      logic        hit;
      logic [30:0] entry_time;
      coord_type   exit_time;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/rae_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating q16.16 result
// depends on rae_pkg
`timescale 1ns / 1ps
`default_nettype none

module rae_div
   import rae_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [32:0] num_mag,
   input  wire logic [31:0] den_mag,
   input  wire logic        neg,
   output coord_type        quo
);

   logic [31:0] rem_ff [0:DIV_STEPS];
   logic [31:0] q_ff   [0:DIV_STEPS];
   logic [31:0] den_ff [0:DIV_STEPS];
   logic [15:0] nlo_ff [0:DIV_STEPS];
   logic        neg_ff [0:DIV_STEPS];
   logic        ovf_ff [0:DIV_STEPS];
   coord_type   quo_ff;
   coord_type   quo_in;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {15'd0, num_mag[32:16]};
         q_ff[0]   <= '0;
         den_ff[0] <= den_mag;
         nlo_ff[0] <= num_mag[15:0];
         neg_ff[0] <= neg;
         ovf_ff[0] <= {15'd0, num_mag[32:16]} >= den_mag;
      end
   end

   for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_step
      logic [32:0] trial;
      logic        ge;
      logic [32:0] diff;
      assign trial = {rem_ff[i-1], nlo_ff[i-1][15]};
      assign ge    = trial >= {1'b0, den_ff[i-1]};
      assign diff  = trial - {1'b0, den_ff[i-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= ge ? diff[31:0] : trial[31:0];
            q_ff[i]   <= {q_ff[i-1][30:0], ge};
            den_ff[i] <= den_ff[i-1];
            nlo_ff[i] <= {nlo_ff[i-1][14:0], 1'b0};
            neg_ff[i] <= neg_ff[i-1];
            ovf_ff[i] <= ovf_ff[i-1];
         end
      end
   end

   always_comb begin
      if (ovf_ff[DIV_STEPS] || q_ff[DIV_STEPS][31]) begin
         quo_in = neg_ff[DIV_STEPS] ? TIME_MIN : TIME_MAX;
      end else if (neg_ff[DIV_STEPS]) begin
         quo_in = -$signed(q_ff[DIV_STEPS]);
      end else begin
         quo_in = $signed(q_ff[DIV_STEPS]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

// File: rtl/rae_lane.sv
// one axis lane: slab classification and near / far plane times
// depends on rae_pkg and rae_div
`timescale 1ns / 1ps
`default_nettype none

module rae_lane
   import rae_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   en,
   input  coord_type   origin,
   input  coord_type   dir,
   input  coord_type   box_min,
   input  coord_type   box_max,
   output lane_out_type lane_out
);

   coord_type          o1_ff, v1_ff, lo1_ff, hi1_ff;
   logic               below1_ff, above1_ff;
   logic signed [32:0] near1_ff, far1_ff;

   lane_side_type      side2_ff;
   logic [32:0]        near_mag2_ff, far_mag2_ff;
   logic [31:0]        den_mag2_ff;
   logic               near_neg2_ff, far_neg2_ff;

   lane_side_type      side_ff [0:DIV_LAT-1];
   lane_side_type      side2_in;
   coord_type          near_q, far_q;

   always_ff @(posedge clock) begin
      if (en) begin
         o1_ff     <= origin;
         v1_ff     <= dir;
         lo1_ff    <= box_min;
         hi1_ff    <= box_max;
         below1_ff <= origin < box_min;
         above1_ff <= !(origin < box_min) && (origin > box_max);
         near1_ff  <= ((origin < box_min) ? 33'(box_min) : 33'(box_max)) - 33'(origin);
         far1_ff   <= (dir[31] ? 33'(box_min) : 33'(box_max)) - 33'(origin);
      end
   end

   always_comb begin
      side2_in.miss    = (below1_ff && (v1_ff <= 0)) || (above1_ff && (v1_ff >= 0));
      side2_in.outside = below1_ff || above1_ff;
      side2_in.v_zero  = v1_ff == 0;
      side2_in.o       = o1_ff;
      side2_in.v       = v1_ff;
      side2_in.lo      = lo1_ff;
      side2_in.hi      = hi1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff     <= side2_in;
         near_mag2_ff <= near1_ff[32] ? 33'(-near1_ff) : 33'(near1_ff);
         far_mag2_ff  <= far1_ff[32] ? 33'(-far1_ff) : 33'(far1_ff);
         den_mag2_ff  <= v1_ff[31] ? 32'(-v1_ff) : 32'(v1_ff);
         near_neg2_ff <= near1_ff[32] ^ v1_ff[31];
         far_neg2_ff  <= far1_ff[32] ^ v1_ff[31];
      end
   end

   rae_div u_near (
      .clock   (clock),
      .en      (en),
      .num_mag (near_mag2_ff),
      .den_mag (den_mag2_ff),
      .neg     (near_neg2_ff),
      .quo     (near_q)
   );

   rae_div u_far (
      .clock   (clock),
      .en      (en),
      .num_mag (far_mag2_ff),
      .den_mag (den_mag2_ff),
      .neg     (far_neg2_ff),
      .quo     (far_q)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side2_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_comb begin
      lane_out.side   = side_ff[DIV_LAT-1];
      lane_out.near_t = near_q;
      lane_out.far_t  = far_q;
   end

endmodule

`default_nettype wire

// File: rtl/rae_merge.sv
// merge stage: entry pick, hit-point check against the other slabs, exit minimum
// depends on rae_pkg
`timescale 1ns / 1ps
`default_nettype none

module rae_merge
   import rae_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   en,
   input  lane_out_type lanes [AXES],
   output result_type  result
);

   logic               best_ok;
   coord_type          best_t;
   logic [1:0]         best_a;
   logic               miss_any;
   coord_type          ext [AXES];
   coord_type          ext_min;

   logic               miss1_ff, check1_ff;
   logic [1:0]         pick1_ff;
   coord_type          entry1_ff, exit1_ff;
   coord_type          o1_ff [AXES];
   coord_type          v1_ff [AXES];
   coord_type          lo1_ff [AXES];
   coord_type          hi1_ff [AXES];

   logic               miss2_ff, check2_ff;
   logic [1:0]         pick2_ff;
   coord_type          entry2_ff, exit2_ff;
   logic signed [63:0] prod2_ff [AXES];
   coord_type          o2_ff [AXES];
   coord_type          lo2_ff [AXES];
   coord_type          hi2_ff [AXES];

   logic               bad;
   result_type         result_ff;
   result_type         result_in;

   always_comb begin
      best_ok  = 1'b0;
      best_t   = '0;
      best_a   = '0;
      miss_any = 1'b0;
      for (int a = 0; a < AXES; a++) begin
         miss_any = miss_any | lanes[a].side.miss;
         if (lanes[a].side.outside && (!best_ok || lanes[a].near_t > best_t)) begin
            best_ok = 1'b1;
            best_t  = lanes[a].near_t;
            best_a  = 2'(a);
         end
         ext[a] = lanes[a].side.v_zero ? TIME_MAX : lanes[a].far_t;
      end
      ext_min = ext[0];
      if (ext[1] < ext_min) begin
         ext_min = ext[1];
      end
      if (ext[2] < ext_min) begin
         ext_min = ext[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         miss1_ff  <= miss_any || (best_ok && best_t < 0);
         check1_ff <= best_ok;
         pick1_ff  <= best_a;
         entry1_ff <= best_ok ? best_t : '0;
         exit1_ff  <= ext_min;
         for (int a = 0; a < AXES; a++) begin
            o1_ff[a]  <= lanes[a].side.o;
            v1_ff[a]  <= lanes[a].side.v;
            lo1_ff[a] <= lanes[a].side.lo;
            hi1_ff[a] <= lanes[a].side.hi;
         end
      end
   end

   // hit point offsets along the other axes
   always_ff @(posedge clock) begin
      if (en) begin
         miss2_ff  <= miss1_ff;
         check2_ff <= check1_ff;
         pick2_ff  <= pick1_ff;
         entry2_ff <= entry1_ff;
         exit2_ff  <= exit1_ff;
         for (int a = 0; a < AXES; a++) begin
            prod2_ff[a] <= $signed({1'b0, entry1_ff[30:0]}) * v1_ff[a];
            o2_ff[a]    <= o1_ff[a];
            lo2_ff[a]   <= lo1_ff[a];
            hi2_ff[a]   <= hi1_ff[a];
         end
      end
   end

   always_comb begin
      logic signed [48:0] p;
      bad = 1'b0;
      for (int a = 0; a < AXES; a++) begin
         p = 49'(o2_ff[a]) + 49'($signed(prod2_ff[a][63:16]));
         if (check2_ff && (pick2_ff != 2'(a)) &&
             ((p < 49'(lo2_ff[a])) || (p > 49'(hi2_ff[a])))) begin
            bad = 1'b1;
         end
      end
      result_in.hit        = !miss2_ff && !bad;
      result_in.entry_time = result_in.hit ? entry2_ff[30:0] : '0;
      result_in.exit_time  = result_in.hit ? exit2_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// File: rtl/ray_aabb_entry_exit_test.sv
// top level of the ray / axis-aligned box entry-exit test
// depends on rae_pkg, rae_lane and rae_merge
//
// request channel (req_*): one transaction carries a ray and a box, twelve
// signed q16.16 words. response channel (rsp_*): one transaction per request
// with the hit flag and the entry and exit times, both zero on a miss.
// three axis lanes run side by side, each with two 32-stage pipelined
// dividers for the near and far plane times; a three-stage merge picks the
// entry plane, checks the hit point and takes the exit minimum.
// depth: 40 register stages (36 in the lanes, the first loaded at the
// accepting edge, 3 in the merge, 1 output register), set by the
// one-bit-per-stage dividers.
// throughput: one transaction per cycle while the skid register is empty.
// reset clears all valid flags; no results are pending afterwards.
// when the receiver stalls, one result parks in a skid register behind the
// output register; the pipeline and req_tready then hold until the output
// register is taken. req_tready is registered.
`timescale 1ns / 1ps
`default_nettype none

module ray_aabb_entry_exit_test
   import rae_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // hit, entry_time[30:0], exit_time[31:0]
   output logic [RSP_W-1:0]      rsp_tdata
);

   logic                vld_ff [0:PIPE_LAT-1];
   logic                out_valid_ff, skid_valid_ff;
   result_type          out_ff, skid_ff;
   lane_out_type        lanes [AXES];
   result_type          result;
   logic                en, arrive, take;

   assign en     = !skid_valid_ff;
   assign arrive = en && vld_ff[PIPE_LAT-1];
   assign take   = out_valid_ff && rsp_tready;

   for (genvar a = 0; a < AXES; a++) begin : g_lane
      rae_lane u_lane (
         .clock    (clock),
         .en       (en),
         .origin   (req_tdata[COORD_W*a +: COORD_W]),
         .dir      (req_tdata[COORD_W*(a+3) +: COORD_W]),
         .box_min  (req_tdata[COORD_W*(a+6) +: COORD_W]),
         .box_max  (req_tdata[COORD_W*(a+9) +: COORD_W]),
         .lane_out (lanes[a])
      );
   end

   rae_merge u_merge (
      .clock  (clock),
      .en     (en),
      .lanes  (lanes),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < PIPE_LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (arrive) begin
         if (!out_valid_ff || take) begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.exit_time, out_ff.entry_time, out_ff.hit};

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   a_skid_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready))
      else $error("skid register filled without a receiver stall");

   a_miss_zero_times: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.hit) |-> (out_ff.entry_time == '0 && out_ff.exit_time == '0))
      else $error("miss reported with nonzero times");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(vld_ff[PIPE_LAT-1]) || !skid_valid_ff)
      else $error("pipeline moved while the skid register was full");

endmodule

`default_nettype wire

// File: tb/sv/ray_aabb_entry_exit_test_tb.sv
// testbench for the ray / axis-aligned box entry-exit test
// depends on rae_pkg and ray_aabb_entry_exit_test; predicts each response
// from the request with a slab-method model and checks it in order
`timescale 1ns / 1ps

class slab_scoreboard;
   logic [63:0] pending_rsp[$];
   int          errors;

   function longint sat_time(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function longint plane_time(longint num, longint den);
      longint scaled;
      scaled = num * 65536;
      return sat_time(scaled / den);
   endfunction

   function logic [63:0] predict_hit(logic [383:0] ray);
      longint o[3], v[3], lo[3], hi[3], t[3], ext[3];
      int zone[3];
      bit all_in;
      int pick, best;
      longint entry, p, prod;
      all_in = 1;
      pick = -1;
      entry = 0;
      for (int a = 0; a < 3; a++) begin
         o[a]  = longint'($signed(ray[32*a +: 32]));
         v[a]  = longint'($signed(ray[32*(3+a) +: 32]));
         lo[a] = longint'($signed(ray[32*(6+a) +: 32]));
         hi[a] = longint'($signed(ray[32*(9+a) +: 32]));
      end
      for (int a = 0; a < 3; a++) begin
         if (o[a] < lo[a]) begin
            if (v[a] <= 0) return 64'd0;
            zone[a] = 0;
            all_in = 0;
         end else if (o[a] > hi[a]) begin
            if (v[a] >= 0) return 64'd0;
            zone[a] = 1;
            all_in = 0;
         end else begin
            zone[a] = -1;
         end
      end
      if (!all_in) begin
         for (int a = 0; a < 3; a++) begin
            if (zone[a] < 0) begin
               t[a] = 0;
            end else begin
               t[a] = plane_time((zone[a] == 0 ? lo[a] : hi[a]) - o[a], v[a]);
               if (pick < 0 || t[a] > t[pick]) pick = a;
            end
         end
         if (pick < 0 || t[pick] < 0) return 64'd0;
         entry = t[pick];
         for (int a = 0; a < 3; a++) begin
            if (a != pick) begin
               prod = entry * v[a];
               p = o[a] + (prod >>> 16);
               if (p < lo[a] || p > hi[a]) return 64'd0;
            end
         end
      end
      for (int a = 0; a < 3; a++) begin
         if (v[a] == 0) ext[a] = 64'sd2147483647;
         else if (v[a] < 0) ext[a] = plane_time(lo[a] - o[a], v[a]);
         else ext[a] = plane_time(hi[a] - o[a], v[a]);
      end
      best = 0;
      if (ext[1] < ext[best]) best = 1;
      if (ext[2] < ext[best]) best = 2;
      return {ext[best][31:0], entry[30:0], 1'b1};
   endfunction

   function void note_request(logic [383:0] ray);
      pending_rsp.push_back(predict_hit(ray));
   endfunction

   function void report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
   endfunction

   function void check_response(logic [63:0] got);
      logic [63:0] want;
      if (pending_rsp.size() == 0) begin
         report_mismatch("unexpected", got, 64'd0);
         return;
      end
      want = pending_rsp.pop_front();
      if (got[0] !== want[0]) report_mismatch("hit", got, want);
      if (got[31:1] !== want[31:1]) report_mismatch("entry_time", got, want);
      if (got[63:32] !== want[63:32]) report_mismatch("exit_time", got, want);
   endfunction
endclass

module testbench;
   import rae_pkg::*;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;

   slab_scoreboard   board;
   bit               calm;
   bit               hold_rsp;
   bit               sending_done;
   longint           cycle_count;

   ray_aabb_entry_exit_test dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'd0;
         default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      endcase
   endfunction

   // random ray and box, mostly a sane box with the ray aimed near it
   function logic [383:0] rand_ray();
      logic [383:0] r;
      logic [31:0]  a, b, c;
      int           mode;
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
         if (mode == 0) begin
            r[32*k +: 32]     = rand_coord();
            r[32*(3+k) +: 32] = rand_coord();
            r[32*(6+k) +: 32] = rand_coord();
            r[32*(9+k) +: 32] = rand_coord();
         end else begin
            a = 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            b = a + $urandom_range(0, 8 << 16);
            c = 32'($signed($urandom_range(0, 60 << 16)) - (30 << 16));
            r[32*(6+k) +: 32] = a;
            r[32*(9+k) +: 32] = b;
            r[32*k +: 32]     = ($urandom_range(0, 9) == 0) ? a : c;
            case ($urandom_range(0, 7))
               0: r[32*(3+k) +: 32] = 32'd0;
               1: r[32*(3+k) +: 32] = $urandom_range(0, 3) - 1;
               2: r[32*(3+k) +: 32] = $urandom;
               default: r[32*(3+k) +: 32] =
                  32'(($signed(a) + $signed(b)) / 2 - $signed(c))
                  + 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
            endcase
         end
      end
      return r;
   endfunction

   task automatic send_ray(logic [383:0] ray);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ray;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(ray);
   endtask

   task automatic stop_req();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (board.pending_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      int n;
      logic [383:0] ray;
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      sending_done = 0;
      calm = 0;
      hold_rsp = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes and special cases
      send_ray('0);
      send_ray('1);
      send_ray({12{32'h8000_0000}});
      send_ray({12{32'h7FFF_FFFF}});
      // inside the box, exit search with a zero axis
      send_ray({{3{32'h0001_0000}}, {3{32'hFFFF_0000}}, 32'd0, 32'd0, 32'h0001_0000,
                {3{32'd0}}});
      // outside on x with zero direction
      send_ray({{3{32'h0001_0000}}, {3{32'hFFFF_0000}}, 32'd0, 32'd0, 32'd0,
                32'd0, 32'd0, 32'h0005_0000});
      // from below x, hitting
      send_ray({{3{32'h0001_0000}}, {3{32'hFFFF_0000}}, 32'd0, 32'd0, 32'h0001_0000,
                32'd0, 32'd0, 32'hFFFB_0000});
      // from above x, hitting
      send_ray({{3{32'h0001_0000}}, {3{32'hFFFF_0000}}, 32'd0, 32'd0, 32'hFFFF_0000,
                32'd0, 32'd0, 32'h0005_0000});
      // moving away above
      send_ray({{3{32'h0001_0000}}, {3{32'hFFFF_0000}}, 32'd0, 32'd0, 32'h0001_0000,
                32'd0, 32'd0, 32'h0005_0000});
      // overflowing division: tiny direction, far plane
      send_ray({{3{32'h7FFF_0000}}, {3{32'h8000_0000}}, 32'd1, 32'd1, 32'd1,
                {3{32'h8000_0000}}});
      // tie on x and y, grazing hit point
      send_ray({{3{32'h0001_0000}}, {3{32'hFFFF_0000}}, 32'd0, 32'h0001_0000,
                32'h0001_0000, 32'd0, 32'hFFFD_0000, 32'hFFFD_0000});
      // inverted box
      send_ray({{3{32'hFFFF_0000}}, {3{32'h0001_0000}}, {3{32'h0001_0000}},
                {3{32'd0}}});
      // hit point misses other slab
      send_ray({{3{32'h0001_0000}}, {3{32'hFFFF_0000}}, 32'd0, 32'h0003_0000,
                32'h0001_0000, 32'd0, 32'd0, 32'hFFFB_0000});
      // negative direction extremes
      send_ray({{3{32'h0001_0000}}, {3{32'hFFFF_0000}}, {3{32'h8000_0000}},
                {3{32'h7FFF_FFFF}}});
      for (int k = 0; k < 8; k++) send_ray(rand_coord() == 0 ? '0 : {12{$urandom}});
      // sender pause until all results are back
      stop_req();
      wait_drained();
      // long receiver hold-off while requests keep coming
      hold_rsp = 1;
      for (int k = 0; k < 120; k++) send_ray(rand_ray());
      stop_req();
      wait_drained();
      for (n = 0; n < 1560; n++) begin
         if (n == 1300) calm = 1;
         ray = rand_ray();
         send_ray(ray);
      end
      stop_req();
      sending_done = 1;
   end

   // receiver: random stalls, one long hold-off
   initial begin
      int hold;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            for (hold = 0; hold < 200; hold++) @(posedge clock);
            hold_rsp = 0;
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 200000) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      wait (sending_done);
      wait_drained();
      repeat (PIPE_LAT + 20) @(posedge clock);
      if (board.errors == 0 && board.pending_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// File: files.f
rtl/rae_pkg.sv
rtl/rae_div.sv
rtl/rae_lane.sv
rtl/rae_merge.sv
rtl/ray_aabb_entry_exit_test.sv
tb/sv/ray_aabb_entry_exit_test_tb.sv
